// File: rtl/adc_channel_trailer_bunch_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the channel trailer and bunch parser
// Shared implication forms used by the top-level checks.
// ----------------------------------------------------------------------------
`ifndef ADC_CHANNEL_TRAILER_BUNCH_PARSER_MACROS_SVH
`define ADC_CHANNEL_TRAILER_BUNCH_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/actb_pkg.sv
// ----------------------------------------------------------------------------
// actb_pkg
// Widths, markers, result codes and the queue entry for the trailer parser.
// ----------------------------------------------------------------------------
package actb_pkg;

  localparam int unsigned WordW = 10;
  localparam int unsigned AddrW = 12;
  localparam int unsigned KindW = 2;
  localparam int unsigned ErrW  = 3;

  localparam logic [WordW-1:0] Marker2AA = 10'h2AA;
  localparam logic [3:0]       MarkA     = 4'hA;

  typedef enum logic [KindW-1:0] {
    KindSample = 2'd0,
    KindEnd    = 2'd1,
    KindError  = 2'd2
  } kind_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone    = 3'd0,
    ErrTrailer = 3'd1,
    ErrMarkHi  = 3'd2,
    ErrMarkMid = 3'd3,
    ErrFill    = 3'd4,
    ErrShort   = 3'd5,
    ErrTime    = 3'd6
  } err_e;

  // Word plus the pre-decoded marker and length flags computed at the front.
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             is_marker;
    logic             hi_mark;
    logic             mid_mark;
    logic             short_len;
  } entry_t;

  typedef struct packed {
    logic load;
    logic load_last;
    logic expect_trailer;
  } back_status_t;

endpackage

// File: rtl/actb_if.sv
// ----------------------------------------------------------------------------
// actb_if
// Valid/ready channels for readout words in and parsed results out.
// ----------------------------------------------------------------------------
interface actb_in_if;
  logic                       valid;
  logic                       ready;
  logic [actb_pkg::WordW-1:0] word;

  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface actb_out_if;
  logic                       valid;
  logic                       ready;
  logic [actb_pkg::KindW-1:0] kind;
  logic [actb_pkg::AddrW-1:0] channel_address;
  logic [actb_pkg::WordW-1:0] time_bin;
  logic [actb_pkg::WordW-1:0] value;
  logic                       last_in_channel;
  logic [actb_pkg::ErrW-1:0]  error_code;

  modport source(output valid, output kind, output channel_address, output time_bin,
                 output value, output last_in_channel, output error_code, input ready);
  modport sink(input valid, input kind, input channel_address, input time_bin,
               input value, input last_in_channel, input error_code, output ready);
endinterface

// File: rtl/actb_front.sv
// ----------------------------------------------------------------------------
// actb_front
// Accepts readout words and tags them with marker and length flags.
// ----------------------------------------------------------------------------
module actb_front (
  actb_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output actb_pkg::entry_t entry_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    entry_o.word      = in_i.word;
    entry_o.is_marker = (in_i.word == actb_pkg::Marker2AA);
    entry_o.hi_mark   = (in_i.word[9:6] == actb_pkg::MarkA);
    entry_o.mid_mark  = (in_i.word[5:2] == actb_pkg::MarkA);
    entry_o.short_len = (in_i.word < 10'd2);
  end

endmodule

// File: rtl/actb_queue.sv
// ----------------------------------------------------------------------------
// actb_queue
// Small register FIFO between the front and the parser back end.
// ----------------------------------------------------------------------------
module actb_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  actb_pkg::entry_t entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output actb_pkg::entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  actb_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: rtl/actb_back.sv
// ----------------------------------------------------------------------------
// actb_back
// Trailer, fill and bunch state machine with a registered result stage.
// ----------------------------------------------------------------------------
module actb_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  actb_pkg::entry_t       head_i,
  output logic                   pop_o,
  output actb_pkg::back_status_t status_o,
  actb_out_if.source             out_o
);

  localparam logic [2:0] PhT0     = 3'd0;
  localparam logic [2:0] PhT1     = 3'd1;
  localparam logic [2:0] PhT2     = 3'd2;
  localparam logic [2:0] PhT3     = 3'd3;
  localparam logic [2:0] PhFill   = 3'd4;
  localparam logic [2:0] PhBlen   = 3'd5;
  localparam logic [2:0] PhBtime  = 3'd6;
  localparam logic [2:0] PhSample = 3'd7;

  logic [2:0]                 phase_q, phase_d;
  logic [9:0]                 count_q, count_d;
  logic [9:0]                 words_q, words_d;
  logic [1:0]                 fill_q, fill_d;
  logic [9:0]                 bunch_q, bunch_d;
  logic [9:0]                 time_q, time_d;
  logic [11:0]                addr_q, addr_d;

  logic                       out_valid_q, out_valid_d;
  actb_pkg::kind_e            kind_q, kind_d;
  logic [11:0]                raddr_q, raddr_d;
  logic [9:0]                 tbin_q, tbin_d;
  logic [9:0]                 val_q, val_d;
  logic                       last_q, last_d;
  actb_pkg::err_e             err_q, err_d;

  logic                       slot_free;
  logic                       load;
  logic [9:0]                 w;

  assign slot_free = !out_valid_q || out_o.ready;
  assign pop_o     = head_valid_i && slot_free;
  assign w         = head_i.word;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    words_d = words_q;
    fill_d  = fill_q;
    bunch_d = bunch_q;
    time_d  = time_q;
    addr_d  = addr_q;
    load    = 1'b0;
    kind_d  = actb_pkg::KindError;
    raddr_d = addr_q;
    tbin_d  = '0;
    val_d   = w;
    last_d  = 1'b1;
    err_d   = actb_pkg::ErrNone;

    if (pop_o) begin
      unique case (phase_q)
        PhT0: begin
          if (!head_i.is_marker) begin
            load    = 1'b1;
            raddr_d = '0;
            err_d   = actb_pkg::ErrTrailer;
            phase_d = PhT0;
          end else begin
            phase_d = PhT1;
          end
        end
        PhT1: begin
          if (!head_i.hi_mark) begin
            load    = 1'b1;
            raddr_d = '0;
            err_d   = actb_pkg::ErrMarkHi;
            phase_d = PhT0;
          end else begin
            count_d = {w[5:0], 4'd0};
            phase_d = PhT2;
          end
        end
        PhT2: begin
          count_d = {count_q[9:4], w[9:6]};
          if (!head_i.mid_mark) begin
            load    = 1'b1;
            raddr_d = '0;
            err_d   = actb_pkg::ErrMarkMid;
            phase_d = PhT0;
          end else begin
            addr_d  = {w[1:0], 10'd0};
            phase_d = PhT3;
          end
        end
        PhT3: begin
          addr_d  = {addr_q[11:10], w};
          words_d = count_q;
          fill_d  = 2'd0 - count_q[1:0];
          if (count_q[1:0] != 2'd0) begin
            phase_d = PhFill;
          end else if (count_q == '0) begin
            // empty channel: close straight away
            load    = 1'b1;
            kind_d  = actb_pkg::KindEnd;
            raddr_d = {addr_q[11:10], w};
            val_d   = count_q;
            phase_d = PhT0;
          end else begin
            phase_d = PhBlen;
          end
        end
        PhFill: begin
          if (!head_i.is_marker) begin
            load    = 1'b1;
            err_d   = actb_pkg::ErrFill;
            phase_d = PhT0;
          end else begin
            fill_d = fill_q - 2'd1;
            if (fill_q == 2'd1) begin
              phase_d = PhBlen;
            end
          end
        end
        PhBlen: begin
          if (head_i.short_len) begin
            load    = 1'b1;
            err_d   = actb_pkg::ErrShort;
            phase_d = PhT0;
          end else begin
            // saturate when the bunch overruns the channel
            words_d = (words_q > w) ? (words_q - w) : '0;
            bunch_d = w - 10'd2;
            phase_d = PhBtime;
          end
        end
        PhBtime: begin
          if (bunch_q == '0) begin
            if (words_q == '0) begin
              load    = 1'b1;
              kind_d  = actb_pkg::KindEnd;
              val_d   = count_q;
              phase_d = PhT0;
            end else begin
              phase_d = PhBlen;
            end
          end else if ((bunch_q - 10'd1) > w) begin
            load    = 1'b1;
            err_d   = actb_pkg::ErrTime;
            phase_d = PhT0;
          end else begin
            time_d  = w;
            phase_d = PhSample;
          end
        end
        PhSample: begin
          load    = 1'b1;
          kind_d  = actb_pkg::KindSample;
          tbin_d  = time_q;
          last_d  = 1'b0;
          bunch_d = bunch_q - 10'd1;
          if (bunch_q == 10'd1) begin
            if (words_q == '0) begin
              last_d  = 1'b1;
              phase_d = PhT0;
            end else begin
              phase_d = PhBlen;
            end
          end else if (time_q != '0) begin
            time_d = time_q - 10'd1;
          end
        end
        default: begin
          phase_d = PhT0;
        end
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhT0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    words_q <= words_d;
    fill_q  <= fill_d;
    bunch_q <= bunch_d;
    time_q  <= time_d;
    addr_q  <= addr_d;
    if (load) begin
      kind_q  <= kind_d;
      raddr_q <= raddr_d;
      tbin_q  <= tbin_d;
      val_q   <= val_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = kind_q;
  assign out_o.channel_address = raddr_q;
  assign out_o.time_bin        = tbin_q;
  assign out_o.value           = val_q;
  assign out_o.last_in_channel = last_q;
  assign out_o.error_code      = err_q;

  always_comb begin
    status_o.load           = load;
    status_o.load_last      = load && last_d;
    status_o.expect_trailer = (phase_q == PhT0);
  end

endmodule

// File: rtl/adc_channel_trailer_bunch_parser.sv
// ----------------------------------------------------------------------------
// adc_channel_trailer_bunch_parser
// Decodes channel trailers, fill words and bunches from reversed readout words.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one 10-bit readout word per beat, last-written word first.
//   out_o carries at most one result per input beat: a sample with address
//   and time bin, a channel end without sample, or an error code.
//   Words that only advance the trailer, fill or bunch header give no beat.
// Path: an accepted word is written into the queue; the parser then takes
//   it from the queue head and loads any result into the result register,
//   which drives out_o.
// Throughput: one word per cycle while out_o.ready is high; the parser
//   handles one queue entry per cycle with compares and counter updates only.
// Stall: when out_o.ready is low the result register holds its beat, the
//   parser stops popping, and the word queue (QueueDepth entries) absorbs
//   input until it fills and in_i.ready falls.
// Reset: the queue empties, the result register clears and the parser waits
//   for the first trailer word. Any error returns it to that point.
// ----------------------------------------------------------------------------
`include "adc_channel_trailer_bunch_parser_macros.svh"

module adc_channel_trailer_bunch_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  actb_in_if.sink   in_i,
  actb_out_if.source out_o
);

  logic                   q_full;
  logic                   q_push;
  actb_pkg::entry_t       q_entry;
  logic                   q_pop;
  logic                   q_head_valid;
  actb_pkg::entry_t       q_head;
  actb_pkg::back_status_t back_st;

  actb_front u_front (
    .in_i    (in_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .entry_o (q_entry)
  );

  actb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .pop_i        (q_pop),
    .full_o       (q_full),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  actb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_head_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .status_o     (back_st),
    .out_o        (out_o)
  );

  `ACTB_ASSERT_NEXT(a_close_rearms, clk_i, rst_ni,
    back_st.load_last, back_st.expect_trailer,
    "channel close did not return to trailer search")
  `ACTB_ASSERT_IMPL(a_error_closes, clk_i, rst_ni,
    out_o.valid && (out_o.kind == actb_pkg::KindError),
    out_o.last_in_channel && (out_o.time_bin == '0),
    "error result must close the channel with time bin zero")
  `ACTB_ASSERT_IMPL(a_end_clean, clk_i, rst_ni,
    out_o.valid && (out_o.kind == actb_pkg::KindEnd),
    out_o.last_in_channel && (out_o.error_code == actb_pkg::ErrNone),
    "channel end must close without error code")
  `ACTB_ASSERT_IMPL(a_sample_clean, clk_i, rst_ni,
    out_o.valid && (out_o.kind == actb_pkg::KindSample),
    out_o.error_code == actb_pkg::ErrNone,
    "sample carries an error code")

endmodule
